>>> hw/rtl/i2cmbe_pkg.sv
// ----------------------------------------------------------------------------
// i2cmbe_pkg
// Shared types and constants for the I2C master bit engine: opcodes, request
// and response payloads, and the item format of the front-to-back queue.
// ----------------------------------------------------------------------------
package i2cmbe_pkg;

   // Bits per data byte on the bus
   localparam int unsigned BYTE_BITS = 8;

   // Width of the phase counter (longest sequence is 3*BYTE_BITS+2 phases)
   localparam int unsigned PHASE_W = 5;

   // Last phase index of each kind of command
   localparam logic [PHASE_W-1:0] LAST_WRITE = PHASE_W'(3 * BYTE_BITS + 1);
   localparam logic [PHASE_W-1:0] LAST_READ  = PHASE_W'(2 * BYTE_BITS - 1);
   localparam logic [PHASE_W-1:0] LAST_SHORT = PHASE_W'(3);

   // Phase at which a write releases SDA for the acknowledge clock
   localparam logic [PHASE_W-1:0] WRITE_ACK_PHASE = PHASE_W'(3 * BYTE_BITS);

   // Command codes
   typedef enum logic [2:0] {
      OP_START = 3'd0,
      OP_STOP  = 3'd1,
      OP_WRITE = 3'd2,
      OP_READ  = 3'd3,
      OP_ACK   = 3'd4,
      OP_NACK  = 3'd5
   } op_type;

   // Sub-step inside one data bit of a write
   typedef enum logic [1:0] {
      SUB_DATA = 2'd0,
      SUB_HIGH = 2'd1,
      SUB_LOW  = 2'd2
   } sub_type;

   // One phase tick as offered on the request channel
   typedef struct packed {
      logic                 cmd_valid;
      logic [2:0]           opcode;
      logic [BYTE_BITS-1:0] write_byte;
      logic                 sda_in;
   } req_type;

   // One phase tick result
   typedef struct packed {
      logic                 scl_level;
      logic                 sda_level;
      logic                 sda_drive;
      logic                 busy_res;
      logic                 done_res;
      logic [BYTE_BITS-1:0] read_data;
      logic                 ack_level;
   } rsp_type;

   // Classified tick held in the queue between front and back
   typedef struct packed {
      logic                 cmd_ok;
      op_type               opcode;
      logic [BYTE_BITS-1:0] write_byte;
      logic                 sda_in;
   } item_type;

endpackage

>>> hw/rtl/i2cmbe_front.sv
// ----------------------------------------------------------------------------
// i2cmbe_front
// Takes request ticks, classifies the offered command and holds the ticks
// in a two-entry queue until the back end executes them.
// ----------------------------------------------------------------------------
module i2cmbe_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  i2cmbe_pkg::req_type  req_payload,
   input  logic                 q_pop,
   output logic                 q_valid,
   output i2cmbe_pkg::item_type q_item
);

   localparam int unsigned DEPTH = 2;

   i2cmbe_pkg::item_type slot_ff [DEPTH];
   logic                 wr_ptr_ff;
   logic                 wr_ptr_in;
   logic                 rd_ptr_ff;
   logic                 rd_ptr_in;
   logic [1:0]           count_ff;
   logic [1:0]           count_in;
   logic                 push;
   logic                 pop;
   i2cmbe_pkg::item_type item_new;

   // Classify: a command counts only if flagged and its code is defined
   always_comb begin
      item_new.cmd_ok     = req_payload.cmd_valid
                            && (req_payload.opcode <= 3'(i2cmbe_pkg::OP_NACK));
      item_new.opcode     = i2cmbe_pkg::op_type'(req_payload.opcode);
      item_new.write_byte = req_payload.write_byte;
      item_new.sda_in     = req_payload.sda_in;
   end

   assign req_ready = (count_ff != 2'(DEPTH));
   assign push      = req_valid && req_ready;
   assign q_valid   = (count_ff != 2'd0);
   assign pop       = q_pop && q_valid;
   assign q_item    = slot_ff[rd_ptr_ff];

   // Advance pointers and fill count
   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Write the queue slot
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= item_new;
      end
   end

endmodule

>>> hw/rtl/i2cmbe_back.sv
// ----------------------------------------------------------------------------
// i2cmbe_back
// Executes one bus phase per queued tick: runs the command sequencer, the
// shift registers and the line levels, and registers the response.
// ----------------------------------------------------------------------------
module i2cmbe_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 q_valid,
   input  i2cmbe_pkg::item_type q_item,
   output logic                 q_pop,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output i2cmbe_pkg::rsp_type  rsp_payload
);

   localparam int unsigned BB = i2cmbe_pkg::BYTE_BITS;
   localparam int unsigned PW = i2cmbe_pkg::PHASE_W;

   // Engine state
   logic                   busy_ff,  busy_in;
   i2cmbe_pkg::op_type     cmd_ff,   cmd_in;
   logic [PW-1:0]          phase_ff, phase_in;
   i2cmbe_pkg::sub_type    sub_ff,   sub_in;
   logic [BB-1:0]          tx_ff,    tx_in;
   logic [BB-1:0]          rx_ff,    rx_in;
   logic                   ack_ff,   ack_in;
   logic                   scl_ff,   scl_in;
   logic                   sda_ff,   sda_in;
   logic                   drv_ff,   drv_in;

   // Response register
   logic                   rsp_valid_ff, rsp_valid_in;
   i2cmbe_pkg::rsp_type    rsp_ff,       rsp_in;

   logic                   start;
   logic                   run;
   logic                   last;
   i2cmbe_pkg::op_type     cmd;
   logic [PW-1:0]          p;
   i2cmbe_pkg::sub_type    sub;
   logic [BB-1:0]          tx;
   logic [BB-1:0]          rx;
   logic                   scl, sda, drv, ack;
   logic [PW-1:0]          last_p;

   assign q_pop = q_valid && (!rsp_valid_ff || rsp_ready);

   // Execute one phase on the head tick
   always_comb begin
      start  = !busy_ff && q_item.cmd_ok;
      run    = busy_ff || start;
      cmd    = start ? q_item.opcode : cmd_ff;
      p      = start ? '0 : phase_ff;
      sub    = start ? i2cmbe_pkg::SUB_DATA : sub_ff;
      tx     = (start && q_item.opcode == i2cmbe_pkg::OP_WRITE) ? q_item.write_byte : tx_ff;
      rx     = (start && q_item.opcode == i2cmbe_pkg::OP_READ) ? '0 : rx_ff;
      scl    = scl_ff;
      sda    = sda_ff;
      drv    = drv_ff;
      ack    = ack_ff;
      sub_in = sub;
      last_p = i2cmbe_pkg::LAST_SHORT;

      if (run) begin
         unique case (cmd) inside
            i2cmbe_pkg::OP_START: begin
               if (p == PW'(0))      sda = 1'b1;
               else if (p == PW'(1)) scl = 1'b1;
               else if (p == PW'(2)) sda = 1'b0;
               else                  scl = 1'b0;
            end
            i2cmbe_pkg::OP_STOP: begin
               if (p == PW'(0))      scl = 1'b0;
               else if (p == PW'(1)) sda = 1'b0;
               else if (p == PW'(2)) scl = 1'b1;
               else                  sda = 1'b1;
            end
            i2cmbe_pkg::OP_ACK, i2cmbe_pkg::OP_NACK: begin
               if (p == PW'(0))      scl = 1'b0;
               else if (p == PW'(1)) sda = (cmd == i2cmbe_pkg::OP_NACK);
               else if (p == PW'(2)) scl = 1'b1;
               else                  scl = 1'b0;
            end
            i2cmbe_pkg::OP_WRITE: begin
               last_p = i2cmbe_pkg::LAST_WRITE;
               if (p < i2cmbe_pkg::WRITE_ACK_PHASE) begin
                  // Data bit in three steps: set SDA, raise SCL, drop SCL
                  unique case (sub)
                     i2cmbe_pkg::SUB_DATA: begin
                        sda    = tx[BB-1];
                        tx     = {tx[BB-2:0], 1'b0};
                        sub_in = i2cmbe_pkg::SUB_HIGH;
                     end
                     i2cmbe_pkg::SUB_HIGH: begin
                        scl    = 1'b1;
                        sub_in = i2cmbe_pkg::SUB_LOW;
                     end
                     default: begin
                        scl    = 1'b0;
                        sub_in = i2cmbe_pkg::SUB_DATA;
                     end
                  endcase
               end else if (p == i2cmbe_pkg::WRITE_ACK_PHASE) begin
                  sda = 1'b1;
                  drv = 1'b0;
                  scl = 1'b1;
               end else begin
                  scl = 1'b0;
                  ack = q_item.sda_in;
               end
            end
            i2cmbe_pkg::OP_READ: begin
               last_p = i2cmbe_pkg::LAST_READ;
               if (!p[0]) begin
                  sda = 1'b1;
                  drv = 1'b0;
                  scl = 1'b1;
               end else begin
                  scl = 1'b0;
                  rx  = {rx[BB-2:0], q_item.sda_in};
               end
            end
            default: begin
            end
         endcase
      end

      last = run && (p >= last_p);

      // Line levels shown for this tick
      rsp_in.scl_level = scl;
      rsp_in.sda_level = sda;
      rsp_in.sda_drive = drv;
      rsp_in.busy_res  = run;
      rsp_in.done_res  = last;
      rsp_in.read_data = rx;
      rsp_in.ack_level = ack;

      // Next state; drive SDA high again after a data byte
      busy_in  = run && !last;
      cmd_in   = cmd;
      phase_in = (run && !last) ? p + PW'(1) : '0;
      if (last) sub_in = i2cmbe_pkg::SUB_DATA;
      tx_in    = tx;
      rx_in    = rx;
      ack_in   = ack;
      scl_in   = scl;
      sda_in   = sda;
      drv_in   = drv;
      if (last && (cmd == i2cmbe_pkg::OP_WRITE || cmd == i2cmbe_pkg::OP_READ)) begin
         sda_in = 1'b1;
         drv_in = 1'b1;
      end
   end

   // Hold or load the response slot
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (q_pop) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         cmd_ff       <= i2cmbe_pkg::OP_START;
         phase_ff     <= '0;
         sub_ff       <= i2cmbe_pkg::SUB_DATA;
         tx_ff        <= '0;
         rx_ff        <= '0;
         ack_ff       <= 1'b1;
         scl_ff       <= 1'b1;
         sda_ff       <= 1'b1;
         drv_ff       <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (q_pop) begin
            busy_ff  <= busy_in;
            cmd_ff   <= cmd_in;
            phase_ff <= phase_in;
            sub_ff   <= sub_in;
            tx_ff    <= tx_in;
            rx_ff    <= rx_in;
            ack_ff   <= ack_in;
            scl_ff   <= scl_in;
            sda_ff   <= sda_in;
            drv_ff   <= drv_in;
         end
      end
   end

   // Response payload
   always_ff @(posedge clock) begin
      if (q_pop) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

>>> hw/rtl/i2c_master_bit_engine_top.sv
// ----------------------------------------------------------------------------
// i2c_master_bit_engine_top
// I2C master line sequencer: one request per bus phase tick, one response
// per request with the SCL/SDA levels, status and received data.
//
//   channel | direction | handshake                  | payload
//   --------+-----------+----------------------------+---------------------
//   req     | in        | req_valid / req_ready      | req_payload (req_type)
//   rsp     | out       | rsp_valid / rsp_ready      | rsp_payload (rsp_type)
//
// One request per clock sustained while rsp_ready is high; a response passes through
// the queue slot, then the phase execution register, after its request is taken.
// The two-entry queue decouples request intake from the response register,
// so req_ready drops only when both slots are occupied.
// Reset is synchronous; it empties the queue and returns the bus to idle
// with SCL and SDA driven high.
// ----------------------------------------------------------------------------
module i2c_master_bit_engine_top (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  i2cmbe_pkg::req_type req_payload,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output i2cmbe_pkg::rsp_type rsp_payload
);

   logic                 q_valid;
   logic                 q_pop;
   i2cmbe_pkg::item_type q_item;

   // Classify and queue incoming ticks
   i2cmbe_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .q_pop       (q_pop),
      .q_valid     (q_valid),
      .q_item      (q_item)
   );

   // Execute phases and register responses
   i2cmbe_back u_back (
      .clock       (clock),
      .reset       (reset),
      .q_valid     (q_valid),
      .q_item      (q_item),
      .q_pop       (q_pop),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

endmodule

>>> hw/rtl/i2cmbe_checker.sv
// ----------------------------------------------------------------------------
// i2cmbe_checker
// Port-level checks on the I2C master bit engine, bound to the top level.
// ----------------------------------------------------------------------------
module i2cmbe_checker (
   input logic                clock,
   input logic                reset,
   input logic                rsp_valid,
   input logic                rsp_ready,
   input i2cmbe_pkg::rsp_type rsp_payload
);

   // No response right after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

   // Hold a stalled response
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_payload)))
      else $error("stalled response changed");

   // Done only on a tick that executes a phase
   a_done_busy: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_payload.done_res) |-> rsp_payload.busy_res)
      else $error("done without busy");

   // SDA is driven whenever the engine is idle
   a_idle_drive: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_payload.busy_res) |-> rsp_payload.sda_drive)
      else $error("SDA released while idle");

   // A released SDA reads as high
   a_release_high: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_payload.sda_drive) |-> rsp_payload.sda_level)
      else $error("SDA low while released");

endmodule

bind i2c_master_bit_engine_top i2cmbe_checker u_i2cmbe_checker (
   .clock       (clock),
   .reset       (reset),
   .rsp_valid   (rsp_valid),
   .rsp_ready   (rsp_ready),
   .rsp_payload (rsp_payload)
);

>>> tb/tb_i2c_master_bit_engine_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_i2c_master_bit_engine_top
// Self-checking bench for the I2C master bit engine. A short command table
// covers every opcode, both byte extremes, ignored opcodes and commands
// offered while busy. Randomized command sequences with random line samples
// follow. The sender works in bursts and the receiver stalls in changing
// patterns. Each response is compared field by field against the bench's bus
// phase predictor, or against the idle response for the first three rows.
// ----------------------------------------------------------------------------
module tb_i2c_master_bit_engine_top;
   import i2cmbe_pkg::*;

   localparam int QUIET_LIMIT  = 1000;
   localparam int DRAIN_CYCLES = 16;
   localparam int ENGINE_TICKS = 1450;

   // Opcodes outside the command set; the engine must ignore them
   localparam logic [2:0] OP_BAD_LO = 3'd6;
   localparam logic [2:0] OP_BAD_HI = 3'd7;

   // Bus state right after reset: lines high and driven, no byte, no ack
   localparam rsp_type RESET_IDLE_RSP = '{scl_level: 1'b1, sda_level: 1'b1,
      sda_drive: 1'b1, busy_res: 1'b0, done_res: 1'b0, read_data: '0,
      ack_level: 1'b1};

   typedef enum logic [1:0] {
      RX_STEADY,
      RX_COIN,
      RX_ALTERNATE,
      RX_BURSTY
   } rx_mode_type;

   // One directed command: first tick offers the command, later ticks run it
   typedef struct packed {
      logic                 cmd_valid;
      logic [2:0]           opcode;
      logic [BYTE_BITS-1:0] write_byte;
      logic [31:0]          sda_bits;
      logic                 nag;
      logic                 typed;
      rsp_type              typed_rsp;
   } dir_row_type;

   localparam dir_row_type DIR_ROWS [14] = '{
      '{1'b0, OP_START,  8'h00, 32'h0000_0000, 1'b0, 1'b1, RESET_IDLE_RSP},
      '{1'b1, OP_BAD_LO, 8'hFF, 32'hFFFF_FFFF, 1'b0, 1'b1, RESET_IDLE_RSP},
      '{1'b1, OP_BAD_HI, 8'h00, 32'h0000_0000, 1'b0, 1'b1, RESET_IDLE_RSP},
      '{1'b1, OP_START,  8'h00, 32'h0000_0000, 1'b1, 1'b0, RESET_IDLE_RSP},
      '{1'b1, OP_WRITE,  8'hFF, 32'h0000_0000, 1'b0, 1'b0, RESET_IDLE_RSP},
      '{1'b1, OP_WRITE,  8'h00, 32'hFFFF_FFFF, 1'b1, 1'b0, RESET_IDLE_RSP},
      '{1'b1, OP_WRITE,  8'hA5, 32'h5555_5555, 1'b0, 1'b0, RESET_IDLE_RSP},
      '{1'b1, OP_READ,   8'h00, 32'hFFFF_FFFF, 1'b0, 1'b0, RESET_IDLE_RSP},
      '{1'b1, OP_READ,   8'hFF, 32'h0000_0000, 1'b1, 1'b0, RESET_IDLE_RSP},
      '{1'b1, OP_READ,   8'h3C, 32'hAAAA_AAAA, 1'b0, 1'b0, RESET_IDLE_RSP},
      '{1'b1, OP_ACK,    8'h00, 32'h0000_0000, 1'b0, 1'b0, RESET_IDLE_RSP},
      '{1'b1, OP_NACK,   8'hFF, 32'hFFFF_FFFF, 1'b1, 1'b0, RESET_IDLE_RSP},
      '{1'b1, OP_STOP,   8'h00, 32'h0000_0000, 1'b0, 1'b0, RESET_IDLE_RSP},
      '{1'b0, OP_WRITE,  8'h00, 32'h0000_0000, 1'b0, 1'b0, RESET_IDLE_RSP}
   };

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_payload = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_payload;

   // Predicted bus engine state
   logic [PHASE_W-1:0]   phase_cnt;
   op_type               cur_op;
   logic                 eng_busy;
   logic [BYTE_BITS-1:0] tx_sr;
   logic [BYTE_BITS-1:0] rx_sr;
   logic                 ack_bit;
   logic                 scl_q;
   logic                 sda_q;
   logic                 drv_q;

   rsp_type exp_ticks [$];
   int      error_count = 0;
   int      engine_ticks = 0;
   int      burst_left = 0;
   int      quiet_cycles = 0;

   rx_mode_type rx_mode = RX_STEADY;
   int          rx_seg_left = 0;
   int unsigned rx_phase = 0;

   i2c_master_bit_engine_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_payload(req_payload),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_payload(rsp_payload)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Advance the predicted engine by one phase tick and return its response
   function automatic rsp_type step_bus(input req_type tick);
      rsp_type            res;
      logic [PHASE_W-1:0] last;
      logic [1:0]         sub;
      res = '0;
      if (!eng_busy && tick.cmd_valid && tick.opcode <= OP_NACK) begin
         eng_busy  = 1'b1;
         cur_op    = op_type'(tick.opcode);
         phase_cnt = '0;
         if (cur_op == OP_WRITE) tx_sr = tick.write_byte;
         if (cur_op == OP_READ) rx_sr = '0;
      end
      if (eng_busy) begin
         case (cur_op)
            OP_START: begin
               case (phase_cnt)
                  0: sda_q = 1'b1;
                  1: scl_q = 1'b1;
                  2: sda_q = 1'b0;
                  default: scl_q = 1'b0;
               endcase
            end
            OP_STOP: begin
               case (phase_cnt)
                  0: scl_q = 1'b0;
                  1: sda_q = 1'b0;
                  2: scl_q = 1'b1;
                  default: sda_q = 1'b1;
               endcase
            end
            OP_ACK, OP_NACK: begin
               case (phase_cnt)
                  0: scl_q = 1'b0;
                  1: sda_q = (cur_op == OP_NACK);
                  2: scl_q = 1'b1;
                  default: scl_q = 1'b0;
               endcase
            end
            OP_WRITE: begin
               if (phase_cnt < WRITE_ACK_PHASE) begin
                  sub = 2'(phase_cnt % PHASE_W'(3));
                  if (sub == SUB_DATA) begin
                     sda_q = tx_sr[BYTE_BITS-1];
                     tx_sr = tx_sr << 1;
                  end else begin
                     scl_q = (sub == SUB_HIGH);
                  end
               end else if (phase_cnt == WRITE_ACK_PHASE) begin
                  sda_q = 1'b1;
                  drv_q = 1'b0;
                  scl_q = 1'b1;
               end else begin
                  scl_q   = 1'b0;
                  ack_bit = tick.sda_in;
               end
            end
            default: begin
               // read: release and raise SCL on even phases, sample on odd
               if (!phase_cnt[0]) begin
                  sda_q = 1'b1;
                  drv_q = 1'b0;
                  scl_q = 1'b1;
               end else begin
                  scl_q = 1'b0;
                  rx_sr = {rx_sr[BYTE_BITS-2:0], tick.sda_in};
               end
            end
         endcase
         res.busy_res = 1'b1;
         if (cur_op == OP_WRITE) last = LAST_WRITE;
         else if (cur_op == OP_READ) last = LAST_READ;
         else last = LAST_SHORT;
         if (phase_cnt >= last) begin
            res.done_res = 1'b1;
            eng_busy     = 1'b0;
            phase_cnt    = '0;
         end else begin
            phase_cnt = phase_cnt + 1'b1;
         end
      end
      res.scl_level = scl_q;
      res.sda_level = sda_q;
      res.sda_drive = drv_q;
      res.read_data = rx_sr;
      res.ack_level = ack_bit;
      // take SDA back after a byte transfer, visible from the next tick
      if (res.done_res && (cur_op == OP_WRITE || cur_op == OP_READ)) begin
         sda_q = 1'b1;
         drv_q = 1'b1;
      end
      return res;
   endfunction

   // Offer one request, hold it until taken, then record its expected response
   task automatic send_tick(input req_type tick, input bit use_typed,
                            input rsp_type typed_rsp);
      rsp_type predicted;
      int      gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                  : $urandom_range(1, 24);
      end
      burst_left--;
      req_valid   <= 1'b1;
      req_payload <= tick;
      do @(posedge clock); while (!req_ready);
      predicted = step_bus(tick);
      engine_ticks++;
      exp_ticks.push_back(use_typed ? typed_rsp : predicted);
   endtask

   task automatic report_mismatch(input string what, input int got, input int want);
      if (error_count < 100)
         $display("%0t ns: %s mismatch: got %0h, expected %0h", $time, what, got, want);
      error_count++;
   endtask

   // Stimulus: reset, directed command table, then random command sequences
   initial begin
      req_type tick;
      int      k;
      int      pick;
      phase_cnt = '0;
      cur_op    = OP_START;
      eng_busy  = 1'b0;
      tx_sr     = '0;
      rx_sr     = '0;
      ack_bit   = 1'b1;
      scl_q     = 1'b1;
      sda_q     = 1'b1;
      drv_q     = 1'b1;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (DIR_ROWS[i]) begin
         k = 0;
         do begin
            // later ticks may offer a stop while busy, which must be dropped
            tick.cmd_valid  = (k == 0) ? DIR_ROWS[i].cmd_valid : DIR_ROWS[i].nag;
            tick.opcode     = (k == 0) ? DIR_ROWS[i].opcode : 3'(OP_STOP);
            tick.write_byte = DIR_ROWS[i].write_byte;
            tick.sda_in     = DIR_ROWS[i].sda_bits[k];
            send_tick(tick, (k == 0) && DIR_ROWS[i].typed, DIR_ROWS[i].typed_rsp);
            k++;
         end while (eng_busy);
      end

      while (engine_ticks < ENGINE_TICKS) begin
         pick            = $urandom_range(0, 99);
         tick.write_byte = 8'($urandom);
         tick.sda_in     = 1'($urandom);
         if (pick < 8) begin
            tick.cmd_valid = 1'b0;
            tick.opcode    = 3'($urandom);
         end else if (pick < 12) begin
            tick.cmd_valid = 1'b1;
            tick.opcode    = 3'($urandom_range(OP_BAD_LO, OP_BAD_HI));
         end else begin
            // weight toward byte transfers, the long sequences
            tick.cmd_valid = 1'b1;
            pick = $urandom_range(0, 9);
            if (pick < 3) tick.opcode = OP_WRITE;
            else if (pick < 6) tick.opcode = OP_READ;
            else if (pick == 6) tick.opcode = OP_START;
            else if (pick == 7) tick.opcode = OP_STOP;
            else if (pick == 8) tick.opcode = OP_ACK;
            else tick.opcode = OP_NACK;
         end
         send_tick(tick, 1'b0, RESET_IDLE_RSP);
         while (eng_busy) begin
            tick.cmd_valid  = ($urandom_range(0, 4) == 0);
            tick.opcode     = 3'($urandom);
            tick.write_byte = 8'($urandom);
            tick.sda_in     = 1'($urandom);
            send_tick(tick, 1'b0, RESET_IDLE_RSP);
         end
      end

      req_valid <= 1'b0;
      while (exp_ticks.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

   // Stall the response side in segments of changing pattern
   always @(posedge clock) begin
      if (rx_seg_left == 0) begin
         rx_mode     = rx_mode_type'($urandom_range(0, 3));
         rx_seg_left = $urandom_range(20, 120);
      end
      rx_seg_left--;
      rx_phase++;
      case (rx_mode)
         RX_STEADY:    rsp_ready <= 1'b1;
         RX_COIN:      rsp_ready <= ($urandom_range(0, 3) != 0);
         RX_ALTERNATE: rsp_ready <= rx_phase[0];
         default:      rsp_ready <= ((rx_phase % 16) >= 12);
      endcase
   end

   // Compare each taken response with the oldest expected one
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (exp_ticks.size() == 0) begin
            report_mismatch("unexpected response", rsp_payload, 0);
         end else begin
            want = exp_ticks.pop_front();
            if (rsp_payload.scl_level !== want.scl_level)
               report_mismatch("scl_level", rsp_payload.scl_level, want.scl_level);
            if (rsp_payload.sda_level !== want.sda_level)
               report_mismatch("sda_level", rsp_payload.sda_level, want.sda_level);
            if (rsp_payload.sda_drive !== want.sda_drive)
               report_mismatch("sda_drive", rsp_payload.sda_drive, want.sda_drive);
            if (rsp_payload.busy_res !== want.busy_res)
               report_mismatch("busy_res", rsp_payload.busy_res, want.busy_res);
            if (rsp_payload.done_res !== want.done_res)
               report_mismatch("done_res", rsp_payload.done_res, want.done_res);
            if (rsp_payload.read_data !== want.read_data)
               report_mismatch("read_data", rsp_payload.read_data, want.read_data);
            if (rsp_payload.ack_level !== want.ack_level)
               report_mismatch("ack_level", rsp_payload.ack_level, want.ack_level);
         end
      end
   end

   // Drop the run when neither channel moves for too long
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

endmodule
